// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the top level rtl file of the value dictionary
// no dependencies; simulation builds get the checks, SYNTH builds get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define VD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("value dictionary assertion failed");

// next-cycle implication, checked out of reset
`define VD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("value dictionary assertion failed");

`else

`define VD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define VD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/vdfl_pkg.sv =====
// types and constants for the value dictionary with free list
// no dependencies; used by the interfaces, the cell and the top level
package vdfl_pkg;

  localparam int DICT_SLOTS = 8;
  localparam int WORD_BITS  = 32;
  localparam int SLOT_BITS  = $clog2(DICT_SLOTS);
  localparam int COUNT_BITS = $clog2(DICT_SLOTS + 1);
  localparam int FUNC_BITS  = 2;
  localparam int ERR_BITS   = 2;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // request operation codes
  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_t;

  // result error codes
  typedef enum logic [ERR_BITS-1:0] {
    ERR_OK     = 2'd0,
    ERR_FULL   = 2'd1,
    ERR_UNUSED = 2'd2
  } err_t;

  // request broadcast to every cell
  typedef struct packed {
    logic                 go;
    logic [FUNC_BITS-1:0] func;
    word_t                word;
    slot_t                rm_slot;
    count_t               lim;
    logic                 any_match;
  } cmd_t;

  // data handed from one cell to the next
  typedef struct packed {
    count_t idx;
    logic   match;
    slot_t  match_slot;
    logic   free;
    slot_t  free_slot;
    count_t free_cnt;
    logic   rm_ok;
  } chain_t;

endpackage

// ===== hw/rtl/vdfl_if.sv =====
// valid/ready channel interfaces for requests and results
// depends on vdfl_pkg
interface vdfl_in_if;
  logic                          valid;
  logic                          ready;
  logic [vdfl_pkg::FUNC_BITS-1:0] func;
  vdfl_pkg::word_t               word_value;
  vdfl_pkg::slot_t               slot_index;

  modport source (output valid, func, word_value, slot_index, input ready);
  modport sink   (input valid, func, word_value, slot_index, output ready);
endinterface

interface vdfl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  vdfl_pkg::slot_t               slot_out;
  logic [vdfl_pkg::ERR_BITS-1:0] error_code;
  vdfl_pkg::count_t              free_count;

  modport source (output valid, hit, slot_out, error_code, free_count, input ready);
  modport sink   (input valid, hit, slot_out, error_code, free_count, output ready);
endinterface

// ===== hw/rtl/vdfl_cell.sv =====
// one dictionary slot: stored word, used bit and its link in the search chain
// depends on vdfl_pkg
module vdfl_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  vdfl_pkg::cmd_t   cmd,
  input  vdfl_pkg::chain_t chain_in,
  output vdfl_pkg::chain_t chain_out
);
  import vdfl_pkg::*;

  word_t word_r;
  logic  used_r;
  logic  used_nxt;
  logic  own_match;
  logic  own_free;
  logic  claim;
  logic  rm_here;
  slot_t my_slot;

  assign my_slot = chain_in.idx[SLOT_BITS-1:0];

  // local compare and free test
  assign own_match = used_r && (word_r == cmd.word);
  assign own_free  = (chain_in.idx < cmd.lim) && !used_r;
  assign rm_here   = used_r && ({1'b0, cmd.rm_slot} == chain_in.idx);

  // lowest free slot claims an insert that matched nowhere
  assign claim = cmd.go && (cmd.func == FUNC_INSERT) && !cmd.any_match
              && own_free && !chain_in.free;

  // pass search results on to the next cell, lower slots win
  always_comb begin
    chain_out.idx        = chain_in.idx + count_t'(1);
    chain_out.match      = chain_in.match | own_match;
    chain_out.match_slot = chain_in.match ? chain_in.match_slot : my_slot;
    chain_out.free       = chain_in.free | own_free;
    chain_out.free_slot  = chain_in.free ? chain_in.free_slot : my_slot;
    chain_out.free_cnt   = chain_in.free_cnt + count_t'(own_free);
    chain_out.rm_ok      = chain_in.rm_ok | rm_here;
  end

  // used bit update
  always_comb begin
    used_nxt = used_r;
    if (claim) begin
      used_nxt = 1'b1;
    end else if (cmd.go && (cmd.func == FUNC_REMOVE) && rm_here) begin
      used_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // stored word, written only when the slot is claimed
  always_ff @(posedge clk) begin
    if (claim) begin
      word_r <= cmd.word;
    end
  end

endmodule

// ===== hw/rtl/value_dictionary_with_free_list.sv =====
// top level of the value dictionary: config register, cell row, result register
// depends on vdfl_pkg, vdfl_if, vdfl_cell and assert_macros.svh
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     func, word_value, slot_index
//   out_ch    out   valid/ready     hit, slot_out, error_code, free_count
//   cfg_*     in    cfg_we          cfg_data (active_entries)
//
// one request per cycle unless a waiting result stalls the input; its result shows in the cycle after the transfer
// the search ripples through the row of slot cells within that cycle
// reset clears every used bit and sets active_entries to all slots
// a waiting result stalls the input only when out_ch is not ready
`include "assert_macros.svh"

module value_dictionary_with_free_list (
  input  logic                       clk,
  input  logic                       rst_n,
  vdfl_in_if.sink                    in_ch,
  vdfl_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  vdfl_pkg::count_t           cfg_data
);
  import vdfl_pkg::*;

  count_t active_r;
  count_t lim;
  logic   accept;
  cmd_t   cmd;
  chain_t chain_w [DICT_SLOTS+1];
  chain_t tail;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 hit_nxt;
  slot_t                slot_nxt;
  logic [ERR_BITS-1:0]  err_nxt;
  count_t               cnt_nxt;
  logic                 hit_r;
  slot_t                slot_r;
  logic [ERR_BITS-1:0]  err_r;
  count_t               cnt_r;

  // active slot count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= count_t'(DICT_SLOTS);
    end else if (cfg_we) begin
      active_r <= cfg_data;
    end
  end

  assign lim = (active_r > count_t'(DICT_SLOTS)) ? count_t'(DICT_SLOTS) : active_r;

  // input transfer
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // request broadcast
  assign tail = chain_w[DICT_SLOTS];
  always_comb begin
    cmd.go        = accept;
    cmd.func      = in_ch.func;
    cmd.word      = in_ch.word_value;
    cmd.rm_slot   = in_ch.slot_index;
    cmd.lim       = lim;
    cmd.any_match = tail.match;
  end

  // row of slot cells
  assign chain_w[0] = '0;
  genvar g;
  generate
    for (g = 0; g < DICT_SLOTS; g++) begin : g_cell
      vdfl_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .chain_in  (chain_w[g]),
        .chain_out (chain_w[g+1])
      );
    end
  endgenerate

  // result from the end of the chain
  always_comb begin
    hit_nxt  = 1'b0;
    slot_nxt = '0;
    err_nxt  = ERR_OK;
    cnt_nxt  = tail.free_cnt;
    case (in_ch.func)
      FUNC_LOOKUP: begin
        if (tail.match) begin
          hit_nxt  = 1'b1;
          slot_nxt = tail.match_slot;
        end
      end
      FUNC_INSERT: begin
        if (tail.match) begin
          hit_nxt  = 1'b1;
          slot_nxt = tail.match_slot;
        end else if (tail.free) begin
          slot_nxt = tail.free_slot;
          cnt_nxt  = tail.free_cnt - count_t'(1);
        end else begin
          err_nxt = ERR_FULL;
        end
      end
      FUNC_REMOVE: begin
        if (tail.rm_ok) begin
          cnt_nxt = tail.free_cnt + count_t'({1'b0, in_ch.slot_index} < lim);
        end else begin
          err_nxt = ERR_UNUSED;
        end
      end
      default: begin
        err_nxt = ERR_OK;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r  <= hit_nxt;
      slot_r <= slot_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = hit_r;
  assign out_ch.slot_out   = slot_r;
  assign out_ch.error_code = err_r;
  assign out_ch.free_count = cnt_r;

  // checks
  `VD_ASSERT_IMPLY(a_full_has_no_free, clk, rst_n, out_valid_r && (err_r == ERR_FULL), cnt_r == '0)
  `VD_ASSERT_IMPLY(a_hit_is_ok, clk, rst_n, out_valid_r && hit_r, err_r == ERR_OK)
  `VD_ASSERT_NEXT(a_transfer_gives_result, clk, rst_n, accept, out_valid_r)

endmodule

// ===== tb/sv/value_dictionary_with_free_list_tb.sv =====
// testbench for the value dictionary with free list: directed and random requests
// depends on vdfl_pkg, vdfl_if and the value_dictionary_with_free_list top level
// results are predicted in-bench and checked field by field in transfer order
`timescale 1ns / 1ps

module value_dictionary_with_free_list_tb;
  import vdfl_pkg::*;

  localparam logic [FUNC_BITS-1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                hit;
    slot_t               slot;
    logic [ERR_BITS-1:0] err;
    count_t              free;
  } dict_result_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_data;

  vdfl_in_if  in_ch ();
  vdfl_out_if out_ch ();

  value_dictionary_with_free_list u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // predicted dictionary contents and setting
  word_t  dict_words [DICT_SLOTS];
  logic   dict_used  [DICT_SLOTS];
  count_t dict_active;

  dict_result_t pending_results [$];
  int mismatch_count;
  int cycle_count;

  // sender burst state
  int burst_left;
  bit no_gaps;

  // long receiver hold-off, requested by a test and counted by the receiver
  int hold_requests;
  int hold_served;
  int hold_cycles;

  // word pool for the random phases
  word_t word_pool [12];

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // slots counted as active, saturated to the dictionary size
  function automatic int active_span();
    return (dict_active > DICT_SLOTS) ? DICT_SLOTS : int'(dict_active);
  endfunction

  // apply one request to the predicted dictionary and return its result
  function automatic dict_result_t dict_apply(logic [FUNC_BITS-1:0] op, word_t w, slot_t idx);
    dict_result_t r;
    int found;
    int lowest;
    int span;
    int n;
    r = '0;
    found = -1;
    lowest = -1;
    span = active_span();
    for (int i = DICT_SLOTS - 1; i >= 0; i--) begin
      if (dict_used[i] && dict_words[i] == w) found = i;
    end
    for (int i = span - 1; i >= 0; i--) begin
      if (!dict_used[i]) lowest = i;
    end
    case (op)
      FUNC_LOOKUP: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.slot = slot_t'(found);
        end
      end
      FUNC_INSERT: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.slot = slot_t'(found);
        end else if (lowest >= 0) begin
          dict_words[lowest] = w;
          dict_used[lowest] = 1'b1;
          r.slot = slot_t'(lowest);
        end else begin
          r.err = ERR_FULL;
        end
      end
      FUNC_REMOVE: begin
        if (dict_used[idx]) begin
          dict_used[idx] = 1'b0;
          dict_words[idx] = '0;
        end else begin
          r.err = ERR_UNUSED;
        end
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < span; i++) begin
      if (!dict_used[i]) n++;
    end
    r.free = count_t'(n);
    return r;
  endfunction

  // offer one request and wait for its transfer; valid stays up for a back-to-back item
  task automatic send_request(logic [FUNC_BITS-1:0] op, word_t w, slot_t idx);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(5, 0);
      burst_left = (($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1));
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.func       <= op;
    in_ch.word_value <= w;
    in_ch.slot_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(dict_apply(op, w, idx));
  endtask

  // drop valid and wait until every result has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the active slot count while the block is idle
  task automatic write_active(count_t value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dict_active = value;
    @(posedge clk);
  endtask

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  function automatic slot_t rand_slot();
    return slot_t'($urandom_range(DICT_SLOTS - 1, 0));
  endfunction

  // receiver: stall pattern of its own, plus a long hold-off on request
  initial begin
    int mode;
    int seg_left;
    out_ch.ready <= 1'b0;
    mode = 0;
    seg_left = 0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        mode = $urandom_range(3, 0);
        seg_left = $urandom_range(60, 5);
      end
      seg_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served++;
        hold_cycles = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1, 0));
          2: out_ch.ready <= ($urandom_range(3, 0) == 0);
          default: out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // result checker: each result transfer against the oldest prediction
  always @(posedge clk) begin
    dict_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none actual hit %0d slot %0d err %0d free %0d",
                 $time, out_ch.hit, out_ch.slot_out, out_ch.error_code, out_ch.free_count);
      end else begin
        e = pending_results.pop_front();
        check_field("hit", 32'(e.hit), 32'(out_ch.hit));
        check_field("slot_out", 32'(e.slot), 32'(out_ch.slot_out));
        check_field("error_code", 32'(e.err), 32'(out_ch.error_code));
        check_field("free_count", 32'(e.free), 32'(out_ch.free_count));
      end
    end
  end

  // empty dictionary: lookup miss, remove of an unused slot, unknown operation
  task automatic test_empty_dict();
    send_request(FUNC_LOOKUP, 32'h0000_0000, rand_slot());
    send_request(FUNC_REMOVE, rand_word(), 3'd7);
    send_request(FUNC_NONE, 32'hFFFF_FFFF, 3'd0);
  endtask

  // fill every slot, overflow, hit on insert, free and reclaim lowest first
  task automatic test_fill_and_reclaim();
    send_request(FUNC_INSERT, 32'h0000_0000, rand_slot());
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, rand_slot());
    send_request(FUNC_INSERT, 32'hA5A5_A5A5, rand_slot());
    send_request(FUNC_INSERT, 32'h5A5A_5A5A, rand_slot());
    send_request(FUNC_INSERT, 32'h8000_0000, rand_slot());
    send_request(FUNC_INSERT, 32'h0000_0001, rand_slot());
    send_request(FUNC_INSERT, 32'h1234_5678, rand_slot());
    send_request(FUNC_INSERT, 32'hFEDC_BA98, rand_slot());
    send_request(FUNC_INSERT, 32'h0F0F_0F0F, rand_slot());
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, rand_slot());
    send_request(FUNC_LOOKUP, 32'h8000_0000, rand_slot());
    send_request(FUNC_REMOVE, rand_word(), 3'd1);
    send_request(FUNC_REMOVE, rand_word(), 3'd1);
    send_request(FUNC_REMOVE, rand_word(), 3'd6);
    send_request(FUNC_INSERT, 32'h7777_7777, rand_slot());
    send_request(FUNC_LOOKUP, 32'h1234_5678, rand_slot());
  endtask

  // shrink, zero and oversize the active range with used slots beyond it
  task automatic test_active_range();
    write_active(count_t'(3));
    send_request(FUNC_LOOKUP, 32'hFEDC_BA98, rand_slot());
    send_request(FUNC_INSERT, 32'h3C3C_3C3C, rand_slot());
    send_request(FUNC_REMOVE, rand_word(), 3'd5);
    send_request(FUNC_REMOVE, rand_word(), 3'd0);
    write_active(count_t'(0));
    send_request(FUNC_INSERT, 32'hC3C3_C3C3, rand_slot());
    send_request(FUNC_LOOKUP, 32'h7777_7777, rand_slot());
    write_active(count_t'(15));
    send_request(FUNC_INSERT, 32'hC3C3_C3C3, rand_slot());
  endtask

  // one random phase: mostly pool words so inserts hit and slots churn
  task automatic run_random_phase(count_t active_value, int items);
    int pick;
    logic [FUNC_BITS-1:0] op;
    word_t w;
    write_active(active_value);
    for (int i = 0; i < 12; i++) word_pool[i] = rand_word();
    if ($urandom_range(1, 0)) begin
      word_pool[0] = '0;
      word_pool[1] = '1;
    end
    no_gaps = ($urandom_range(3, 0) == 0);
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) op = FUNC_INSERT;
      else if (pick < 70) op = FUNC_LOOKUP;
      else if (pick < 95) op = FUNC_REMOVE;
      else op = FUNC_NONE;
      w = ($urandom_range(9, 0) == 0) ? rand_word() : word_pool[$urandom_range(11, 0)];
      send_request(op, w, rand_slot());
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    wait_idle();
    hold_requests++;
    no_gaps = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_request(($urandom_range(1, 0) ? FUNC_INSERT : FUNC_LOOKUP),
                   word_pool[$urandom_range(11, 0)], rand_slot());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    count_t phase_active [10];
    phase_active = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd2, 4'd7, 4'd8, 4'd12, 4'd1};
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_LOOKUP;
    in_ch.word_value <= '0;
    in_ch.slot_index <= '0;
    mismatch_count = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_requests = 0;
    hold_served = 0;
    hold_cycles = 0;
    dict_active = count_t'(DICT_SLOTS);
    for (int i = 0; i < DICT_SLOTS; i++) begin
      dict_used[i] = 1'b0;
      dict_words[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_dict();
    test_fill_and_reclaim();
    test_active_range();
    for (int p = 0; p < 10; p++) begin
      run_random_phase(phase_active[p], 166);
      if (p == 4) test_backpressure();
    end

    // drain and finish
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t missing results: expected %0d more actual 0", $time, pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vdfl_pkg.sv
hw/rtl/vdfl_if.sv
hw/rtl/vdfl_cell.sv
hw/rtl/value_dictionary_with_free_list.sv
tb/sv/value_dictionary_with_free_list_tb.sv
